// ===== rtl/pvt_pkg.sv =====
// ============================================================================
// pvt_pkg
// Shared types and constants for the peer value table with TTL expiry.
// ============================================================================
package pvt_pkg;

    // Default table size and field widths
    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_W         = 48;
    localparam int VALUE_W       = 32;
    localparam int TIME_W        = 32;
    localparam int TTL_W         = 20;

    // TTL after reset, in milliseconds
    localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(10000);

    // Operation carried in tuser of the input stream
    typedef enum logic
    {
        OP_STORE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

endpackage

// ===== rtl/peer_value_table_with_ttl.sv =====
// ============================================================================
// peer_value_table_with_ttl
// Associative table of peer values keyed by 48-bit address, with TTL expiry.
// ============================================================================
//
// Usage:
//   Input beats arrive on s_axis: tuser selects store or query, tdata carries
//   the peer address, the sample value and the current millisecond time.
//   Every input beat yields exactly one result beat on m_axis: tdata is the
//   value read on a fresh query hit (else zero), tuser carries the hit and
//   eviction flags.
//   A store overwrites the matching entry, or takes the lowest free slot, then
//   the lowest expired slot, then the oldest entry (flagged as eviction).
//   Each beat is registered in the input register, then in the result register.
//   Throughput: one beat per cycle unless m_axis stalls; the key compare and
//   the oldest-entry search run in parallel over all slots between the input
//   register and the result register, and the table is written at the edge
//   the result loads. When m_axis stalls, the result is held and the input
//   register stays full, so s_axis_tready drops until the result is taken.
//   Reset clears all slot valid bits and loads the TTL with 10000 ms.
//   cfg_we writes cfg_wdata into the TTL register; write only when idle.
//
module peer_value_table_with_ttl
#(
    parameter int TABLE_ENTRIES = pvt_pkg::TABLE_ENTRIES
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    // Configuration: TTL in milliseconds
    input  logic                          cfg_we,
    input  logic [pvt_pkg::TTL_W-1:0]     cfg_wdata,

    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [47:0] peer_address, [79:48] sample_value, [111:80] time_now
    input  logic [111:0]                  s_axis_tdata,
    // [0] opcode
    input  logic [0:0]                    s_axis_tuser,

    // Result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] value_out
    output logic [31:0]                   m_axis_tdata,
    // [0] hit_flag, [1] evicted_flag
    output logic [1:0]                    m_axis_tuser
);

    localparam int KEY_W   = pvt_pkg::KEY_W;
    localparam int VALUE_W = pvt_pkg::VALUE_W;
    localparam int TIME_W  = pvt_pkg::TIME_W;
    localparam int TTL_W   = pvt_pkg::TTL_W;
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int LEAVES  = 1 << IDX_W;
    localparam int NODES   = 2 * LEAVES - 1;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic [TTL_W-1:0]   ttl_reg;

    logic               in_valid_reg;
    pvt_pkg::op_t       in_op_reg;
    logic [KEY_W-1:0]   in_key_reg;
    logic [VALUE_W-1:0] in_value_reg;
    logic [TIME_W-1:0]  in_now_reg;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_hit_reg;
    logic               out_evict_reg;

    logic               slot_valid_reg [TABLE_ENTRIES];
    logic [KEY_W-1:0]   slot_key_reg   [TABLE_ENTRIES];
    logic [VALUE_W-1:0] slot_value_reg [TABLE_ENTRIES];
    logic [TIME_W-1:0]  slot_stamp_reg [TABLE_ENTRIES];

    // ------------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------------
    logic in_fire;
    logic work_fire;
    logic in_valid_next;
    logic out_valid_next;

    assign work_fire     = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || work_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end
        out_valid_next = work_fire || (out_valid_reg && !m_axis_tready);
    end

    // ------------------------------------------------------------------------
    // Per-slot match and age
    // ------------------------------------------------------------------------
    logic [TABLE_ENTRIES-1:0] match_vec;
    logic [TABLE_ENTRIES-1:0] expired_vec;
    logic [TIME_W-1:0]        slot_age [TABLE_ENTRIES];

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            slot_age[i]    = in_now_reg - slot_stamp_reg[i];
            expired_vec[i] = slot_age[i] >= TIME_W'(ttl_reg);
            match_vec[i]   = slot_valid_reg[i] && (slot_key_reg[i] == in_key_reg);
        end
    end

    // Keys are unique, so at most one slot matches: OR-encode it
    logic               hit_any;
    logic               fresh_any;
    logic [IDX_W-1:0]   match_idx;
    logic [VALUE_W-1:0] match_value;

    always_comb
    begin
        match_idx   = '0;
        match_value = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (match_vec[i])
            begin
                match_idx   = match_idx | IDX_W'(i);
                match_value = match_value | slot_value_reg[i];
            end
        end
        hit_any   = |match_vec;
        fresh_any = |(match_vec & ~expired_vec);
    end

    // Lowest free slot and lowest expired slot
    logic             free_any;
    logic             exp_any;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] exp_idx;

    always_comb
    begin
        free_any = 1'b0;
        exp_any  = 1'b0;
        free_idx = '0;
        exp_idx  = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
            if (expired_vec[i])
            begin
                exp_any = 1'b1;
                exp_idx = IDX_W'(i);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Oldest slot: compare tree, left (lower index) wins on ties
    // ------------------------------------------------------------------------
    logic [TIME_W-1:0] tree_age [NODES];
    logic [IDX_W-1:0]  tree_idx [NODES];

    genvar g;
    generate
        for (g = 0; g < LEAVES; g++)
        begin : g_leaf
            if (g < TABLE_ENTRIES)
            begin : g_real
                assign tree_age[LEAVES-1+g] = slot_age[g];
                assign tree_idx[LEAVES-1+g] = IDX_W'(g);
            end
            else
            begin : g_pad
                // padding sits right of every real slot and never wins
                assign tree_age[LEAVES-1+g] = '0;
                assign tree_idx[LEAVES-1+g] = '0;
            end
        end
        for (g = 0; g < LEAVES - 1; g++)
        begin : g_node
            logic right_wins;
            assign right_wins  = tree_age[2*g+2] > tree_age[2*g+1];
            assign tree_age[g] = right_wins ? tree_age[2*g+2] : tree_age[2*g+1];
            assign tree_idx[g] = right_wins ? tree_idx[2*g+2] : tree_idx[2*g+1];
        end
    endgenerate

    // ------------------------------------------------------------------------
    // Store target and result
    // ------------------------------------------------------------------------
    logic               is_store;
    logic               evict;
    logic [IDX_W-1:0]   target_idx;
    logic [VALUE_W-1:0] res_value;
    logic               res_hit;
    logic               res_evict;

    always_comb
    begin
        is_store = (in_op_reg == pvt_pkg::OP_STORE);
        evict    = !hit_any && !free_any && !exp_any;

        if (hit_any)
        begin
            target_idx = match_idx;
        end
        else if (free_any)
        begin
            target_idx = free_idx;
        end
        else if (exp_any)
        begin
            target_idx = exp_idx;
        end
        else
        begin
            target_idx = tree_idx[0];
        end

        if (is_store)
        begin
            res_value = '0;
            res_hit   = hit_any;
            res_evict = evict;
        end
        else
        begin
            res_value = fresh_any ? match_value : '0;
            res_hit   = fresh_any;
            res_evict = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg       <= pvt_pkg::TTL_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                ttl_reg <= cfg_wdata;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (work_fire && is_store && !hit_any)
            begin
                slot_valid_reg[target_idx] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers and table contents
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_op_reg    <= pvt_pkg::op_t'(s_axis_tuser[0]);
            in_key_reg   <= s_axis_tdata[47:0];
            in_value_reg <= s_axis_tdata[79:48];
            in_now_reg   <= s_axis_tdata[111:80];
        end
        if (work_fire)
        begin
            out_value_reg <= res_value;
            out_hit_reg   <= res_hit;
            out_evict_reg <= res_evict;
        end
        if (work_fire && is_store)
        begin
            slot_value_reg[target_idx] <= in_value_reg;
            slot_stamp_reg[target_idx] <= in_now_reg;
            if (!hit_any)
            begin
                slot_key_reg[target_idx] <= in_key_reg;
            end
        end
    end

    // Outputs
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = {out_evict_reg, out_hit_reg};

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: peer value table with TTL expiry
// Drives store and query beats into the table and checks every result beat
// against an in-bench model of the slots, the TTL aging and the eviction order.
// The run steps through several TTL settings, including zero and full scale,
// with random stalls on both streams and one long result-side hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES = pvt_pkg::TABLE_ENTRIES;
    localparam int KEY_W         = pvt_pkg::KEY_W;
    localparam int VALUE_W       = pvt_pkg::VALUE_W;
    localparam int TIME_W        = pvt_pkg::TIME_W;
    localparam int TTL_W         = pvt_pkg::TTL_W;

    localparam int KEY_POOL    = 24;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_PRINTS  = 40;

    // Expected result of one beat
    typedef struct packed
    {
        logic [VALUE_W-1:0] value;
        logic               hit;
        logic               evicted;
    } peer_result_t;

    // DUT connections, all known from time zero
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [TTL_W-1:0]     cfg_wdata     = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [47:0] peer_address, [79:48] sample_value, [111:80] time_now
    logic [111:0]         s_axis_tdata  = '0;
    // [0] opcode
    logic [0:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [31:0] value_out
    logic [31:0]          m_axis_tdata;
    // [0] hit_flag, [1] evicted_flag
    logic [1:0]           m_axis_tuser;

    // Model of the table
    logic                 mdl_valid [TABLE_ENTRIES];
    logic [KEY_W-1:0]     mdl_key   [TABLE_ENTRIES];
    logic [VALUE_W-1:0]   mdl_value [TABLE_ENTRIES];
    logic [TIME_W-1:0]    mdl_stamp [TABLE_ENTRIES];
    logic [TTL_W-1:0]     mdl_ttl;

    peer_result_t         expected_results [$];

    // Stimulus state
    logic [KEY_W-1:0]     key_pool [KEY_POOL];
    logic [TIME_W-1:0]    cur_time;
    bit                   idle_on  = 1'b0;
    bit                   hold_req = 1'b0;

    // Statistics
    int                   err_count   = 0;
    int                   n_beats     = 0;
    int                   n_checked   = 0;
    int                   n_query_hit = 0;
    int                   n_overwrite = 0;
    int                   n_evict     = 0;
    int                   n_ttl       = 0;

    peer_value_table_with_ttl u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Hard limit on run time
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------
    task automatic table_clear();
        int i;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            mdl_valid[i] = 1'b0;
            mdl_key[i]   = '0;
            mdl_value[i] = '0;
            mdl_stamp[i] = '0;
        end
        mdl_ttl = pvt_pkg::TTL_RESET;
    endtask

    // Apply one beat to the model and return the result it must produce
    function automatic peer_result_t table_apply(pvt_pkg::op_t op, logic [KEY_W-1:0] key,
                                                 logic [VALUE_W-1:0] val,
                                                 logic [TIME_W-1:0] now);
        peer_result_t      res;
        int                slot;
        int                oldest;
        int                i;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] oldest_age;
        logic [TIME_W-1:0] ttl_w;

        res        = '0;
        slot       = -1;
        oldest     = 0;
        oldest_age = '0;
        ttl_w      = TIME_W'(mdl_ttl);

        for (i = 0; i < TABLE_ENTRIES; i++)
            if (slot < 0 && mdl_valid[i] && mdl_key[i] == key)
                slot = i;

        if (op == pvt_pkg::OP_QUERY)
        begin
            if (slot >= 0)
            begin
                age = now - mdl_stamp[slot];
                if (age < ttl_w)
                begin
                    res.value = mdl_value[slot];
                    res.hit   = 1'b1;
                end
            end
        end
        else
        begin
            if (slot >= 0)
                res.hit = 1'b1;
            else
            begin
                // free slot, then stale slot, then the oldest live one
                for (i = 0; i < TABLE_ENTRIES; i++)
                    if (slot < 0 && !mdl_valid[i])
                        slot = i;
                for (i = 0; i < TABLE_ENTRIES; i++)
                begin
                    age = now - mdl_stamp[i];
                    if (slot < 0 && age >= ttl_w)
                        slot = i;
                end
                if (slot < 0)
                begin
                    for (i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        age = now - mdl_stamp[i];
                        if (i == 0 || age > oldest_age)
                        begin
                            oldest_age = age;
                            oldest     = i;
                        end
                    end
                    slot        = oldest;
                    res.evicted = 1'b1;
                end
                mdl_valid[slot] = 1'b1;
                mdl_key[slot]   = key;
            end
            mdl_value[slot] = val;
            mdl_stamp[slot] = now;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Shared driver, report and config tasks
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("[%0t] mismatch on %s: got 0x%08h, want 0x%08h", $time, what, got, want);
    endtask

    // Send one beat, wait for acceptance, then queue its expected result
    task automatic send_beat(pvt_pkg::op_t op, logic [KEY_W-1:0] key,
                             logic [VALUE_W-1:0] val, logic [TIME_W-1:0] now);
        int           gap;
        peer_result_t res;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, val, key};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = table_apply(op, key, val, now);
        expected_results.push_back(res);
        n_beats++;
        if (op == pvt_pkg::OP_QUERY && res.hit)
            n_query_hit++;
        if (op == pvt_pkg::OP_STORE && res.hit)
            n_overwrite++;
        if (res.evicted)
            n_evict++;
    endtask

    // Stop sending and wait until every result beat has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_ttl(logic [TTL_W-1:0] ttl);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= ttl;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mdl_ttl = ttl;
        n_ttl++;
    endtask

    // Random beat: mostly keys from a small pool so entries get hit,
    // overwritten, aged out and evicted; time mostly creeps forward
    task automatic send_random_beat();
        int                 r;
        int unsigned        span;
        logic [KEY_W-1:0]   key;
        pvt_pkg::op_t       op;

        span = (mdl_ttl / 16 < 4) ? 4 : mdl_ttl / 16;
        r = $urandom_range(0, 99);
        if (r < 45)
            cur_time = cur_time;
        else if (r < 65)
            cur_time = cur_time + $urandom_range(0, 3);
        else if (r < 92)
            cur_time = cur_time + $urandom_range(0, span);
        else if (r < 97)
            cur_time = $urandom;
        else
            cur_time = cur_time + mdl_ttl - $urandom_range(0, 1);

        if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        else
            key = {16'($urandom), 32'($urandom)};
        op = pvt_pkg::op_t'($urandom_range(0, 1));
        send_beat(op, key, $urandom, cur_time);
    endtask

    task automatic refill_key_pool();
        int i;
        for (i = 0; i < KEY_POOL; i++)
            key_pool[i] = {16'($urandom), 32'($urandom)};
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    initial
    begin : result_check
        peer_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result beat", m_axis_tdata, '0);
                else
                begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (m_axis_tdata !== want.value)
                        report_mismatch("value_out", m_axis_tdata, want.value);
                    if (m_axis_tuser[0] !== want.hit)
                        report_mismatch("hit_flag", 32'(m_axis_tuser[0]), 32'(want.hit));
                    if (m_axis_tuser[1] !== want.evicted)
                        report_mismatch("evicted_flag", 32'(m_axis_tuser[1]),
                                        32'(want.evicted));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random stalls, and a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 6);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, TTL boundary, time wrap, stale overwrite, absent key
    task automatic test_directed();
        idle_on = 1'b1;
        send_beat(pvt_pkg::OP_QUERY, 48'h0,            32'h0,         32'h0000_0000);
        send_beat(pvt_pkg::OP_STORE, 48'h0,            32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_beat(pvt_pkg::OP_QUERY, 48'h0,            32'h0,         32'h0000_0010);
        send_beat(pvt_pkg::OP_STORE, 48'hFFFF_FFFF_FFFF, 32'h0,       32'hFFFF_FFFF);
        // age one below and exactly at the reset TTL
        send_beat(pvt_pkg::OP_QUERY, 48'hFFFF_FFFF_FFFF, 32'h0,       32'h0000_270E);
        send_beat(pvt_pkg::OP_QUERY, 48'hFFFF_FFFF_FFFF, 32'h0,       32'h0000_270F);
        // stale entry is overwritten in place
        send_beat(pvt_pkg::OP_STORE, 48'hFFFF_FFFF_FFFF, 32'h1234_5678, 32'h0000_4000);
        send_beat(pvt_pkg::OP_QUERY, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_4000);
        send_beat(pvt_pkg::OP_QUERY, 48'h0,            32'h0,         32'h0000_4000);
        send_beat(pvt_pkg::OP_STORE, 48'hA5A5_5A5A_0F0F, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
        send_beat(pvt_pkg::OP_QUERY, 48'h5A5A_A5A5_F0F0, 32'h0,       32'h0000_4000);
        send_beat(pvt_pkg::OP_STORE, 48'h0,            32'h0,         32'h0000_4000);
        send_beat(pvt_pkg::OP_QUERY, 48'h0,            32'h0,         32'h0000_4001);
        send_beat(pvt_pkg::OP_QUERY, 48'hA5A5_5A5A_0F0F, 32'h0,       32'h0000_0000);
    endtask

    task automatic test_random(int n_items, logic [TTL_W-1:0] ttl, bit allow_idle);
        int i;
        write_ttl(ttl);
        refill_key_pool();
        for (i = 0; i < n_items; i++)
        begin
            // alternate stretches with and without stalls
            if (i % 50 == 0)
                idle_on = allow_idle && ($urandom_range(0, 2) != 0);
            send_random_beat();
        end
    endtask

    // Sink holds off long enough for the result and input registers to fill and stall the input
    task automatic test_backpressure();
        int i;
        write_ttl(TTL_W'($urandom_range(1, 1000000)));
        idle_on  = 1'b0;
        hold_req = 1'b1;
        for (i = 0; i < 30; i++)
            send_random_beat();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        table_clear();
        cur_time = 32'hFFFF_F000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(350, TTL_W'(20'hFFFFF), 1'b1);
        test_random(350, TTL_W'(1), 1'b1);
        test_random(300, TTL_W'(0), 1'b1);
        test_backpressure();
        test_random(350, TTL_W'($urandom_range(1, 1000000)), 1'b1);
        test_random(550, TTL_W'(10000), 1'b0);

        drain_results();
        repeat (8) @(posedge clk);

        $display("Covered %0d beats checked of %0d sent across %0d TTL settings.",
                 n_checked, n_beats, n_ttl);
        $display("Fresh query hits %0d, store overwrites %0d, live evictions %0d.",
                 n_query_hit, n_overwrite, n_evict);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
